/* hdl/prb_pkg.sv */
// ============================================================================
// prb_pkg: shared types and constants for the packet ring buffer
// Item layouts, command and status codes, controller states and the
// command/status groups passed between the controller and the datapath.
// ============================================================================
package prb_pkg;

  localparam int CFG_W          = 5;
  localparam int WORD_W         = 64;
  localparam int BC_W           = 4;
  localparam int LEN_W          = 10;
  localparam int BYTES_PER_WORD = 8;
  localparam int FIRST_BYTE_BIT = 7;   // bit 7 of the first byte (mask 0x80)

  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(16);

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_MARKER = 2'd1,
    CMD_POP    = 2'd2,
    CMD_CLEAR  = 2'd3
  } prb_cmd_t;

  typedef enum logic [1:0] {
    ST_RECEIVED  = 2'd0,
    ST_FINISH    = 2'd1,
    ST_POP_DATA  = 2'd2,
    ST_POP_EMPTY = 2'd3
  } prb_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_READ,
    S_POP_SEND
  } prb_state_t;

  typedef struct packed {
    prb_cmd_t            command;
    logic [WORD_W-1:0]   data_word;
    logic [BC_W-1:0]     byte_count;
    logic                last_word;
  } prb_in_t;

  typedef struct packed {
    prb_status_t         status;
    logic [WORD_W-1:0]   data_word_res;
    logic [BC_W-1:0]     byte_count_res;
    logic                last;
    logic [LEN_W-1:0]    packet_length;
    logic                dropped_oldest;
    logic                truncated;
  } prb_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic exec;        // carry out the accepted command this cycle
    logic rd_en;       // read the next word of the packet being popped
    logic load_word;   // load a popped word into the result register
  } prb_ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;    // result register can take a new item this cycle
    logic count_zero;  // no stored packets
    logic pop_last;    // the word being popped is the final one
  } prb_stat_t;

endpackage

/* hdl/prb_ctrl.sv */
// ============================================================================
// prb_ctrl: command sequencer for the packet ring buffer
// Writes, markers, clears and empty pops run from idle; a pop walks the stored words of one
// packet through the word memory and the result register.
// ============================================================================
module prb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  prb_pkg::prb_cmd_t   command,
  input  prb_pkg::prb_stat_t  stat,
  output logic                cmd_stall,
  output prb_pkg::prb_ctrl_t  ctrl
);
  import prb_pkg::*;

  prb_state_t state;
  prb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && stat.out_free && (command == CMD_POP) && !stat.count_zero) begin
          state_next = S_POP_READ;
        end
      end
      S_POP_READ: begin
        state_next = S_POP_SEND;
      end
      S_POP_SEND: begin
        if (stat.out_free && stat.pop_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_stall      = 1'b1;
    ctrl.exec      = 1'b0;
    ctrl.rd_en     = 1'b0;
    ctrl.load_word = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_stall = !stat.out_free;
        ctrl.exec = cmd_valid && stat.out_free;
      end
      S_POP_READ: begin
        ctrl.rd_en = 1'b1;
      end
      S_POP_SEND: begin
        ctrl.load_word = stat.out_free;
        ctrl.rd_en     = stat.out_free && !stat.pop_last;
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

endmodule

/* hdl/prb_dp.sv */
// ============================================================================
// prb_dp: datapath of the packet ring buffer
// Ring pointers and count, per-slot lengths, the packet word memory and the
// result register.
// ============================================================================
module prb_dp #(
  parameter int NUM_SLOTS  = 16,
  parameter int SLOT_WORDS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [prb_pkg::CFG_W-1:0]     cfg_wr_data,
  input  prb_pkg::prb_in_t              cmd_item,
  input  prb_pkg::prb_ctrl_t            ctrl,
  output prb_pkg::prb_stat_t            stat,
  input  logic                          res_stall,
  output logic                          res_valid,
  output prb_pkg::prb_out_t             res_item
);
  import prb_pkg::*;

  localparam int PTR_W  = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int OFF_W  = $clog2(SLOT_WORDS + 1);
  localparam int KW     = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
  localparam int DEPTH  = NUM_SLOTS * SLOT_WORDS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Configuration and ring state.
  logic [CFG_W-1:0] slots_in_use;
  logic [CNT_W-1:0] ring_len;
  logic [PTR_W-1:0] write_slot, write_slot_next;
  logic [PTR_W-1:0] read_slot, read_slot_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic [OFF_W-1:0] word_offset, word_offset_next;
  logic             first_byte_high, first_byte_high_next;
  logic             overflow_seen, overflow_seen_next;
  logic             drop_pending, drop_pending_next;
  logic [LEN_W-1:0] cur_len, cur_len_next;
  logic [LEN_W-1:0] slot_length [NUM_SLOTS];

  // Pop walk.
  logic [PTR_W-1:0] pop_slot, pop_slot_next;
  logic [LEN_W-1:0] pop_len, pop_len_next;
  logic [LEN_W-1:0] pop_rem, pop_rem_next;
  logic [KW-1:0]    pop_word, pop_word_next;
  logic             pop_last;
  logic [KW-1:0]    rd_word;

  // Slot length write port.
  logic             sl_we;
  logic [PTR_W-1:0] sl_addr;
  logic [LEN_W-1:0] sl_wdata;

  // Word memory.
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] ram_q;
  logic              mem_we;
  logic [OFF_W-1:0]  mem_wword;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;

  // Per-command working values.
  logic             begin_pkt;
  logic             full;
  logic [CNT_W-1:0] count_base;
  logic [PTR_W-1:0] read_base;
  logic             drop_base;
  logic [BC_W-1:0]  bc_clamp;
  logic [BC_W-1:0]  add;
  logic [LEN_W-1:0] len_base;
  logic             ovf_base;
  logic             fbh_base;
  logic             room;
  logic [LEN_W-1:0] len_new;
  logic             ovf_new;

  logic     res_load;
  prb_out_t res_data;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= len) ? '0 : n[PTR_W-1:0];
  endfunction

  // The ring length is the register value held to the range 2..NUM_SLOTS.
  always_comb begin
    if (CMP_W'(slots_in_use) < CMP_W'(2)) begin
      ring_len = CNT_W'(2);
    end else if (CMP_W'(slots_in_use) > CMP_W'(NUM_SLOTS)) begin
      ring_len = CNT_W'(NUM_SLOTS);
    end else begin
      ring_len = CNT_W'(slots_in_use);
    end
  end

  assign pop_last = (pop_rem <= LEN_W'(BYTES_PER_WORD));
  assign rd_word  = ctrl.load_word ? (pop_word + KW'(1)) : pop_word;

  assign stat.out_free   = !res_valid || !res_stall;
  assign stat.count_zero = (stored_count == '0);
  assign stat.pop_last   = pop_last;

  always_comb begin
    begin_pkt  = (word_offset == '0);
    full       = begin_pkt && (stored_count >= ring_len);
    count_base = full ? (ring_len - CNT_W'(1)) : stored_count;
    read_base  = full ? advance(read_slot, ring_len) : read_slot;
    drop_base  = full || drop_pending;
    bc_clamp   = (cmd_item.byte_count > BC_W'(BYTES_PER_WORD)) ? BC_W'(BYTES_PER_WORD)
                                                                 : cmd_item.byte_count;
    add        = cmd_item.last_word ? bc_clamp : BC_W'(BYTES_PER_WORD);
    len_base   = begin_pkt ? '0 : cur_len;
    ovf_base   = begin_pkt ? 1'b0 : overflow_seen;
    fbh_base   = begin_pkt ? cmd_item.data_word[FIRST_BYTE_BIT] : first_byte_high;
    room       = (word_offset < OFF_W'(SLOT_WORDS));
    len_new    = room ? (len_base + LEN_W'(add)) : len_base;
    ovf_new    = ovf_base || !room;
  end

  always_comb begin
    write_slot_next      = write_slot;
    read_slot_next       = read_slot;
    stored_count_next    = stored_count;
    word_offset_next     = word_offset;
    first_byte_high_next = first_byte_high;
    overflow_seen_next   = overflow_seen;
    drop_pending_next    = drop_pending;
    cur_len_next         = cur_len;
    pop_slot_next        = pop_slot;
    pop_len_next         = pop_len;
    pop_rem_next         = pop_rem;
    pop_word_next        = pop_word;
    sl_we                = 1'b0;
    sl_addr              = write_slot;
    sl_wdata             = '0;
    mem_we               = 1'b0;
    mem_wword            = word_offset;
    mem_wdata            = cmd_item.data_word;
    res_load             = 1'b0;
    res_data             = '0;

    if (ctrl.exec) begin
      unique case (cmd_item.command)
        CMD_WRITE: begin
          read_slot_next       = read_base;
          stored_count_next    = count_base;
          drop_pending_next    = drop_base;
          first_byte_high_next = fbh_base;
          overflow_seen_next   = ovf_new;
          cur_len_next         = len_new;
          sl_we                = 1'b1;
          sl_wdata             = len_new;
          if (room) begin
            mem_we           = 1'b1;
            word_offset_next = word_offset + OFF_W'(1);
          end
          if (cmd_item.last_word) begin
            res_load                = 1'b1;
            res_data.status         = fbh_base ? ST_RECEIVED : ST_FINISH;
            res_data.packet_length  = len_new;
            res_data.dropped_oldest = drop_base;
            res_data.truncated      = ovf_new;
            write_slot_next         = advance(write_slot, ring_len);
            stored_count_next       = count_base + CNT_W'(1);
            word_offset_next        = '0;
            first_byte_high_next    = 1'b0;
            overflow_seen_next      = 1'b0;
            drop_pending_next       = 1'b0;
          end
        end
        CMD_MARKER: begin
          // A partly written packet is abandoned; a drop it caused is kept.
          read_slot_next          = read_base;
          mem_we                  = 1'b1;
          mem_wword               = '0;
          mem_wdata               = '0;
          sl_we                   = 1'b1;
          sl_wdata                = LEN_W'(1);
          res_load                = 1'b1;
          res_data.status         = ST_FINISH;
          res_data.packet_length  = LEN_W'(1);
          res_data.dropped_oldest = drop_base;
          write_slot_next         = advance(write_slot, ring_len);
          stored_count_next       = count_base + CNT_W'(1);
          word_offset_next        = '0;
          first_byte_high_next    = 1'b0;
          overflow_seen_next      = 1'b0;
          drop_pending_next       = 1'b0;
        end
        CMD_POP: begin
          if (stored_count == '0) begin
            res_load        = 1'b1;
            res_data.status = ST_POP_EMPTY;
          end else begin
            pop_slot_next     = read_slot;
            pop_len_next      = slot_length[read_slot];
            pop_rem_next      = slot_length[read_slot];
            pop_word_next     = '0;
            sl_we             = 1'b1;
            sl_addr           = read_slot;
            sl_wdata          = '0;
            // Keep the running length in step if the emptied slot is being written.
            if (read_slot == write_slot) begin
              cur_len_next = '0;
            end
            read_slot_next    = advance(read_slot, ring_len);
            stored_count_next = stored_count - CNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          write_slot_next      = '0;
          read_slot_next       = '0;
          stored_count_next    = '0;
          word_offset_next     = '0;
          first_byte_high_next = 1'b0;
          overflow_seen_next   = 1'b0;
          drop_pending_next    = 1'b0;
        end
      endcase
    end

    if (ctrl.load_word) begin
      res_load               = 1'b1;
      res_data.status        = ST_POP_DATA;
      res_data.data_word_res = (pop_rem == '0) ? '0 : ram_q;
      res_data.byte_count_res = pop_last ? pop_rem[BC_W-1:0] : BC_W'(BYTES_PER_WORD);
      res_data.last          = pop_last;
      res_data.packet_length = pop_len;
      pop_rem_next           = pop_rem - LEN_W'(BYTES_PER_WORD);
      pop_word_next          = pop_word + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use    <= SLOTS_RESET;
      write_slot      <= '0;
      read_slot       <= '0;
      stored_count    <= '0;
      word_offset     <= '0;
      first_byte_high <= 1'b0;
      overflow_seen   <= 1'b0;
      drop_pending    <= 1'b0;
      cur_len         <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_length[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        slots_in_use <= cfg_wr_data;
      end
      write_slot      <= write_slot_next;
      read_slot       <= read_slot_next;
      stored_count    <= stored_count_next;
      word_offset     <= word_offset_next;
      first_byte_high <= first_byte_high_next;
      overflow_seen   <= overflow_seen_next;
      drop_pending    <= drop_pending_next;
      cur_len         <= cur_len_next;
      if (sl_we) begin
        slot_length[sl_addr] <= sl_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pop_slot <= pop_slot_next;
    pop_len  <= pop_len_next;
    pop_rem  <= pop_rem_next;
    pop_word <= pop_word_next;
  end

  assign mem_waddr = ADDR_W'(write_slot) * ADDR_W'(SLOT_WORDS) + ADDR_W'(mem_wword);
  assign mem_raddr = ADDR_W'(pop_slot) * ADDR_W'(SLOT_WORDS) + ADDR_W'(rd_word);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      ram_q <= mem[mem_raddr];
    end
  end

  // Result register: loaded only when it is empty or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_item <= res_data;
    end
  end

endmodule

/* hdl/packet_ring_buffer_drop_oldest.sv */
// ============================================================================
// packet_ring_buffer_drop_oldest: ring of packet slots keeping recent packets
// Packets are written as 64-bit words and committed on the last word. When
// every slot in use is occupied, the oldest packet is dropped as a new one
// begins. A pop streams the oldest packet out word by word.
// ============================================================================
//
//   port group    | role        | handshake
//   --------------+-------------+-----------------------------------------
//   cmd_*         | item in     | cmd_valid / cmd_stall, payload cmd_item
//   res_*         | item out    | res_valid / res_stall, payload res_item
//   cfg_*         | slots_in_use| cfg_wr_en / cfg_wr_data, no wait
//
// Write words, markers, clears and empty pops are taken from idle, so packet
// words stream in at one item per cycle while the result register is free.
// A pop of a stored packet holds the input through acceptance, a word memory
// read, and then one word out per cycle while the result register is free.
// Synchronous reset clears pointers, count and slot lengths; the word memory
// is not cleared. cmd_stall is high during a pop and while a result is stalled.
//
module packet_ring_buffer_drop_oldest #(
  parameter int NUM_SLOTS  = 16,
  parameter int SLOT_WORDS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [prb_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  prb_pkg::prb_in_t          cmd_item,
  output logic                      res_valid,
  input  logic                      res_stall,
  output prb_pkg::prb_out_t         res_item
);
  import prb_pkg::*;

  // Command and status groups between the sequencer and the datapath.
  prb_ctrl_t ctrl;
  prb_stat_t stat;

  // The sequencer decides when an item is taken and walks pops one word
  // at a time; all storage lives in the datapath.
  prb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .command   (cmd_item.command),
    .stat      (stat),
    .cmd_stall (cmd_stall),
    .ctrl      (ctrl)
  );

  // The datapath holds the ring pointers, the per-slot lengths, the packet
  // word memory and the result register that parts the two channels.
  prb_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .SLOT_WORDS (SLOT_WORDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_item    (cmd_item),
    .ctrl        (ctrl),
    .stat        (stat),
    .res_stall   (res_stall),
    .res_valid   (res_valid),
    .res_item    (res_item)
  );

endmodule
